[rtl/core/zsid_pkg.sv]
// Shared types, constants and the threshold table of the z-score impulse detector.
// Used by the front, queue, back and top-level modules; depends on nothing.
package zsid_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SENS_W = 2;
  localparam int THR_W = 19;
  localparam int FRAC_W = 16;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SENS_W-1:0] SENS_ANY = 2'd0;
  localparam logic [SENS_W-1:0] SENS_LOW = 2'd1;
  localparam logic [SENS_W-1:0] SENS_MID = 2'd2;
  localparam logic [SENS_W-1:0] SENS_HIGH = 2'd3;
  localparam logic [SENS_W-1:0] SENS_RESET = SENS_MID;

  localparam logic [THR_W-1:0] THR_SQ_ANY = 19'd0;
  localparam logic [THR_W-1:0] THR_SQ_LOW = 19'd14171;
  localparam logic [THR_W-1:0] THR_SQ_MID = 19'd177342;
  localparam logic [THR_W-1:0] THR_SQ_HIGH = 19'd495616;

  typedef enum logic [0:0] {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_DIFF,
    B_MULT,
    B_CMP,
    B_HOLD
  } back_state_t;

  // Squared z-score threshold with 16 fractional bits.
  function automatic logic [THR_W-1:0] thr_sq(input logic [SENS_W-1:0] sel);
    logic [THR_W-1:0] t;
    case (sel)
      SENS_ANY: t = THR_SQ_ANY;
      SENS_LOW: t = THR_SQ_LOW;
      SENS_MID: t = THR_SQ_MID;
      SENS_HIGH: t = THR_SQ_HIGH;
      default: t = THR_SQ_ANY;
    endcase
    return t;
  endfunction

endpackage

[rtl/core/zscore_impulse_detector.sv]
// Top level of the z-score impulse detector.
// Depends on zsid_pkg, zsid_front, zsid_queue and zsid_back.
//
// Usage: samples enter on the input channel (sample, in_valid, in_ready) and
// one result leaves per sample on the output channel (shot_detected,
// window_valid, out_valid, out_ready). A result flags a shot when the sample's
// z-score against the nonzero entries of the last WINDOW_DEPTH samples exceeds
// the threshold picked by the sensitivity register (cfg_we, cfg_wdata).
// Write the register only while no sample is in flight.
// The front end takes a new sample only after it has finished the last one,
// limited by the window RAM read before each update. The back end scores one
// sample at a time through its product, difference, multiply, compare and hold
// steps, which sets the sustained rate.
// A two-entry queue sits between the two parts, and the output register lets
// the back end start the next sample while a result waits.
// When out_ready stays low, the back end, then the queue and finally in_ready
// stall; no result is lost.
// Reset empties the window at once without a clearing pass and sets the
// sensitivity to 2.
module zscore_impulse_detector
  import zsid_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SENS_W-1:0]   cfg_wdata,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                shot_detected,
  output logic                window_valid,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int QW = 2 * SAMPLE_W + CW;
  localparam int QDW = SAMPLE_W + CW + SW + QW;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic [QDW-1:0] q_wdata;
  logic [QDW-1:0] q_rdata;

  zsid_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  zsid_queue #(
    .WIDTH(QDW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  zsid_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_rdata      (q_rdata),
    .shot_detected(shot_detected),
    .window_valid (window_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

[rtl/core/zsid_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the sample window.
module zsid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/zsid_front.sv]
// Front end: accepts samples, keeps the ring window and its running statistics.
// Depends on zsid_pkg and zsid_ram; pushes a statistics snapshot per sample.
module zsid_front
  import zsid_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                q_full,
  output logic                q_push,
  output logic [4 * SAMPLE_W + 3 * $clog2(WINDOW_DEPTH + 1) - 1:0] q_wdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int QW = 2 * SAMPLE_W + CW;
  localparam int SQW = 2 * SAMPLE_W;

  front_state_t fstate;
  front_state_t fstate_next;

  logic                rd_en;
  logic                wr_en;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] x_reg;
  logic [AW-1:0]       wpos;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       count;
  logic [SW-1:0]       sum;
  logic [QW-1:0]       sqsum;

  logic [SAMPLE_W-1:0] old;
  logic [SQW-1:0]      old_sq;
  logic [SQW-1:0]      x_sq;
  logic [CW-1:0]       count_next;
  logic [SW-1:0]       sum_next;
  logic [QW-1:0]       sqsum_next;

  zsid_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wpos),
    .wdata(x_reg),
    .re   (rd_en),
    .raddr(wpos),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_comb begin
    fstate_next = fstate;
    rd_en = 1'b0;
    wr_en = 1'b0;
    q_push = 1'b0;
    case (fstate)
      F_IDLE: begin
        if (in_valid) begin
          rd_en = 1'b1;
          fstate_next = F_UPDATE;
        end
      end
      F_UPDATE: begin
        if (!q_full) begin
          wr_en = 1'b1;
          q_push = 1'b1;
          fstate_next = F_IDLE;
        end
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  assign in_ready = (fstate == F_IDLE);

  // Entries not yet written since reset read as empty.
  assign old = (fill > CW'(wpos)) ? rd_data : '0;
  assign old_sq = SQW'(old) * SQW'(old);
  assign x_sq = SQW'(x_reg) * SQW'(x_reg);
  assign count_next = count - CW'(old != '0) + CW'(x_reg != '0);
  assign sum_next = sum - SW'(old) + SW'(x_reg);
  assign sqsum_next = sqsum - QW'(old_sq) + QW'(x_sq);

  assign q_wdata = {x_reg, count, sum, sqsum};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      x_reg <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      fill <= '0;
      count <= '0;
      sum <= '0;
      sqsum <= '0;
    end else if (wr_en) begin
      count <= count_next;
      sum <= sum_next;
      sqsum <= sqsum_next;
      if (wpos == AW'(WINDOW_DEPTH - 1)) begin
        wpos <= '0;
      end else begin
        wpos <= wpos + AW'(1);
      end
      if (fill != CW'(WINDOW_DEPTH)) begin
        fill <= fill + CW'(1);
      end
    end
  end

endmodule

[rtl/core/zsid_queue.sv]
// Two-entry queue that carries statistics snapshots from the front to the back.
// Depends on zsid_pkg for its depth.
module zsid_queue
  import zsid_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   level;

  assign full = (level == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (level == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      level <= level + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
    end
  end

endmodule

[rtl/core/zsid_back.sv]
// Back end: scores one snapshot with an exact integer z-score test over several steps.
// Depends on zsid_pkg; holds the sensitivity register and the output register.
module zsid_back
  import zsid_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SENS_W-1:0]   cfg_wdata,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [2 * SAMPLE_W + SAMPLE_W + SAMPLE_W
                + 3 * $clog2(WINDOW_DEPTH + 1) - 1:0] q_rdata,
  output logic                shot_detected,
  output logic                window_valid,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int QW = 2 * SAMPLE_W + CW;
  localparam int N2W = 2 * SW;
  localparam int SPW = CW + QW;
  localparam int SPL = SPW / 2;
  localparam int SPH = SPW - SPL;
  localparam int RLW = THR_W + SPL;
  localparam int RHW = THR_W + SPH;
  localparam int LHW = N2W + FRAC_W;
  localparam int RW = THR_W + SPW;
  localparam int CMPW = (LHW > RW) ? LHW : RW;

  back_state_t bstate;
  back_state_t bstate_next;

  logic [SENS_W-1:0]   sens;
  logic                load;
  logic [SAMPLE_W-1:0] x_r;
  logic [CW-1:0]       n_r;
  logic [SW-1:0]       s_r;
  logic [QW-1:0]       q_r;
  logic [SW-1:0]       nx;
  logic [SPW-1:0]      nq;
  logic [SPW-1:0]      s2;
  logic [SW-1:0]       num;
  logic                above;
  logic [SPW-1:0]      spread;
  logic [N2W-1:0]      num2;
  logic [RLW-1:0]      rp_lo;
  logic [RHW-1:0]      rp_hi;
  logic [THR_W-1:0]    thr;
  logic [CMPW-1:0]     lhs;
  logic [CMPW-1:0]     rhs;
  logic                res_shot;
  logic                res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens <= SENS_RESET;
    end else if (cfg_we) begin
      sens <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  always_comb begin
    bstate_next = bstate;
    q_pop = 1'b0;
    load = 1'b0;
    case (bstate)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          bstate_next = B_PROD;
        end
      end
      B_PROD: bstate_next = B_DIFF;
      B_DIFF: bstate_next = B_MULT;
      B_MULT: bstate_next = B_CMP;
      B_CMP: bstate_next = B_HOLD;
      B_HOLD: begin
        if (!out_valid || out_ready) begin
          load = 1'b1;
          bstate_next = B_IDLE;
        end
      end
      default: bstate_next = B_IDLE;
    endcase
  end

  assign thr = thr_sq(sens);
  assign lhs = CMPW'(num2) << FRAC_W;
  assign rhs = CMPW'(rp_lo) + (CMPW'(rp_hi) << SPL);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      q_r <= q_rdata[QW-1:0];
      s_r <= q_rdata[QW +: SW];
      n_r <= q_rdata[QW + SW +: CW];
      x_r <= q_rdata[QW + SW + CW +: SAMPLE_W];
    end
    case (bstate)
      B_PROD: begin
        nx <= SW'(n_r) * SW'(x_r);
        nq <= SPW'(n_r) * SPW'(q_r);
        s2 <= SPW'(s_r) * SPW'(s_r);
      end
      B_DIFF: begin
        num <= nx - s_r;
        above <= (nx > s_r);
        spread <= (nq > s2) ? (nq - s2) : '0;
      end
      B_MULT: begin
        num2 <= N2W'(num) * N2W'(num);
        rp_lo <= RLW'(thr) * RLW'(spread[SPL-1:0]);
        rp_hi <= RHW'(thr) * RHW'(spread[SPW-1:SPL]);
      end
      B_CMP: begin
        res_valid <= (n_r != '0);
        res_shot <= (n_r != '0) && above && (lhs > rhs);
      end
      default: begin
      end
    endcase
    if (load) begin
      shot_detected <= res_shot;
      window_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the z-score impulse detector, built on its RTL and zsid_pkg.
// An in-bench scorer predicts each result from the samples sent on the input channel.
// Random back-pressure and sender gaps cover the handshakes.
module testbench;
  import zsid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic shot;
    logic valid;
  } detection_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SENS_W-1:0]   cfg_wdata;
  logic [SAMPLE_W-1:0] sample;
  logic                in_valid;
  logic                in_ready;
  logic                shot_detected;
  logic                window_valid;
  logic                out_valid;
  logic                out_ready;

  zscore_impulse_detector #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample       (sample),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .shot_detected(shot_detected),
    .window_valid (window_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  // Scorer state, kept in step with the accepted samples.
  logic [SAMPLE_W-1:0] history[DEPTH];
  logic [SLOT_W-1:0]   write_slot;
  logic [63:0]         live_count;
  logic [63:0]         level_sum;
  logic [63:0]         level_square_sum;
  logic [SENS_W-1:0]   threshold_sel;

  detection_t pending_detections[$];
  int         error_count;
  bit         idle_enable;
  int         hold_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [127:0] threshold_sq(input logic [SENS_W-1:0] sel);
    logic [127:0] t;
    case (sel)
      SENS_ANY: t = 128'(THR_SQ_ANY);
      SENS_LOW: t = 128'(THR_SQ_LOW);
      SENS_MID: t = 128'(THR_SQ_MID);
      default: t = 128'(THR_SQ_HIGH);
    endcase
    return t;
  endfunction

  // Compares num^2 * 2^16 against T^2 * spread, with no square root.
  function automatic detection_t score_sample(input logic [SAMPLE_W-1:0] x);
    detection_t   d;
    logic [127:0] n, nx, num, nq, s2, spread, lhs, rhs;
    n = 128'(live_count);
    d.valid = (live_count != '0);
    d.shot = 1'b0;
    nx = n * 128'(x);
    if (live_count != '0 && nx > 128'(level_sum)) begin
      num = nx - 128'(level_sum);
      if (threshold_sel == SENS_ANY) begin
        d.shot = 1'b1;
      end else begin
        nq = n * 128'(level_square_sum);
        s2 = 128'(level_sum) * 128'(level_sum);
        spread = (nq > s2) ? nq - s2 : '0;
        lhs = (num * num) << FRAC_W;
        rhs = threshold_sq(threshold_sel) * spread;
        d.shot = (lhs > rhs);
      end
    end
    return d;
  endfunction

  task automatic advance_window(input logic [SAMPLE_W-1:0] x);
    logic [63:0] old;
    old = 64'(history[write_slot]);
    if (old != '0) begin
      live_count = live_count - 64'd1;
      level_sum -= old;
      level_square_sum -= old * old;
    end
    if (x != '0) begin
      live_count = live_count + 64'd1;
      level_sum += 64'(x);
      level_square_sum += 64'(x) * 64'(x);
    end
    history[write_slot] = x;
    write_slot = (write_slot == SLOT_W'(DEPTH - 1)) ? '0 : write_slot + SLOT_W'(1);
  endtask

  // Offers one beat and returns at the edge that accepts it, with valid left high.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample <= value;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_detections.push_back(score_sample(value));
    advance_window(value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sensitivity(input logic [SENS_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_sel = value;
  endtask

  // Mostly a noisy baseline with occasional impulses, silence and wild values.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int baseline, input int noise);
    int v;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      v = baseline + $urandom_range(0, 2 * noise) - noise;
    end else if (kind < 16) begin
      v = baseline + $urandom_range(noise, 30000);
    end else if (kind == 16) begin
      return '0;
    end else begin
      return SAMPLE_W'($urandom_range(0, 65535));
    end
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic run_random(input int count);
    int baseline, noise;
    baseline = $urandom_range(50, 60000);
    noise = $urandom_range(1, 3000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        baseline = $urandom_range(50, 60000);
        noise = $urandom_range(1, 3000);
      end
      send_sample(pick_sample(baseline, noise));
    end
  endtask

  task automatic test_directed_cases();
    logic [SAMPLE_W-1:0] cases[$];
    cases = '{16'd1000, 16'd0, 16'd1000, 16'd1000, 16'd999, 16'd1001, 16'd1001,
              16'd65535, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd32768, 16'd32767,
              16'd1200, 16'd1100, 16'd5000, 16'd65535, 16'd0, 16'd2};
    foreach (cases[i]) send_sample(cases[i]);
    drain_results();
  endtask

  task automatic test_sensitivity_sweep();
    logic [SENS_W-1:0] order[4];
    order = '{SENS_HIGH, SENS_ANY, SENS_LOW, SENS_MID};
    foreach (order[i]) begin
      write_sensitivity(order[i]);
      run_random(370);
      drain_results();
    end
  endtask

  // Enough silence to flush every live entry, so the window reads empty again.
  task automatic test_silence_refill();
    write_sensitivity(SENS_LOW);
    for (int i = 0; i < DEPTH + 2; i++) send_sample('0);
    send_sample(16'd40000);
    send_sample(16'd40000);
    send_sample(16'd40001);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    idle_enable = 1'b0;
    write_sensitivity(SENS_MID);
    hold_cycles = 200;
    run_random(40);
    drain_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_full_rate();
    idle_enable = 1'b0;
    write_sensitivity(SENS_ANY);
    run_random(150);
    drain_results();
    write_sensitivity(SENS_HIGH);
    run_random(150);
    drain_results();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    sample <= '0;
    in_valid <= 1'b0;
    foreach (history[i]) history[i] = '0;
    write_slot = '0;
    live_count = '0;
    level_sum = '0;
    level_square_sum = '0;
    threshold_sel = SENS_MID;
    error_count = 0;
    idle_enable = 1'b1;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_sensitivity_sweep();
    test_silence_refill();
    test_output_backpressure();
    test_full_rate();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The receiver counts its own long hold-off, then stalls in short random bursts.
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 8) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    detection_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_detections.size() == 0) begin
        $error("Result beat arrived with no sample outstanding.");
        error_count++;
      end else begin
        want = pending_detections.pop_front();
        if (shot_detected !== want.shot) begin
          $error("shot_detected: expected %0b, got %0b", want.shot, shot_detected);
          error_count++;
        end
        if (window_valid !== want.valid) begin
          $error("window_valid: expected %0b, got %0b", want.valid, window_valid);
          error_count++;
        end
      end
    end
  end

endmodule
